// File: hw/rtl/yrf_pkg.sv
// yrf_pkg: shared types, BT.601 coefficients and a clamp helper for the
// YUV -> RGB -> fade -> YUV pixel pipeline. No dependencies.
`timescale 1ns / 1ps

package yrf_pkg;

  localparam int PIX_W = 8;

  // YUV -> RGB coefficients (8-bit fixed point)
  localparam logic signed [10:0] C_Y   = 11'sd298;
  localparam logic signed [10:0] C_RV  = 11'sd409;
  localparam logic signed [10:0] C_GU  = 11'sd100;
  localparam logic signed [10:0] C_GV  = 11'sd208;
  localparam logic signed [10:0] C_BU  = 11'sd516;

  // RGB -> YUV coefficients
  localparam logic signed [8:0] C_YR = 9'sd66;
  localparam logic signed [8:0] C_YG = 9'sd129;
  localparam logic signed [8:0] C_YB = 9'sd25;
  localparam logic signed [8:0] C_UR = -9'sd38;
  localparam logic signed [8:0] C_UG = -9'sd74;
  localparam logic signed [8:0] C_UB = 9'sd112;
  localparam logic signed [8:0] C_VR = 9'sd112;
  localparam logic signed [8:0] C_VG = -9'sd94;
  localparam logic signed [8:0] C_VB = -9'sd18;

  localparam logic signed [10:0] OFS_Y = 11'sd16;
  localparam logic signed [10:0] OFS_C = 11'sd128;

  localparam logic [PIX_W-1:0] FADE_RESET = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
  } yuv_t;

  function automatic logic [PIX_W-1:0] clamp12(input logic signed [11:0] v);
    logic [PIX_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > 12'sd255) begin
      res = '1;
    end else begin
      res = v[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/yuv_rgb_fade_yuv_pixel_core.sv
// yuv_rgb_fade_yuv_pixel_core: top level of the BT.601 YUV -> RGB -> fade
// -> YUV pixel pipeline. Depends on yrf_pkg, yrf_rgb_stage, yrf_fade_stage,
// yrf_yuv_stage.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-----------------
//   input   | in_luma_in, in_cb_in, in_cr_in          | in_valid/in_ready
//   result  | out_luma_out, out_cb_out, out_cr_out    | out_valid/out_ready
//   config  | cfg_fade_level                          | cfg_we, no wait
//
// Five register stages: chroma/luma products, RGB clamp, fade multiply,
// YUV products, YUV saturate. One request per cycle unless the output stalls.
// Each stage carries its own valid bit and holds when the stage after it is
// full and stalled, so bubbles are squeezed out and nothing is lost.
// Synchronous active-low reset clears valid bits and sets fade level to 255.
`timescale 1ns / 1ps

module yuv_rgb_fade_yuv_pixel_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [yrf_pkg::PIX_W-1:0]  cfg_fade_level,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [yrf_pkg::PIX_W-1:0]  in_luma_in,
  input  logic [yrf_pkg::PIX_W-1:0]  in_cb_in,
  input  logic [yrf_pkg::PIX_W-1:0]  in_cr_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [yrf_pkg::PIX_W-1:0]  out_luma_out,
  output logic [yrf_pkg::PIX_W-1:0]  out_cb_out,
  output logic [yrf_pkg::PIX_W-1:0]  out_cr_out
);
  import yrf_pkg::*;

  logic [PIX_W-1:0] fade_r;
  logic             rgb_valid, rgb_ready;
  logic             fade_valid, fade_ready;
  rgb_t             rgb, rgb_faded;
  yuv_t             yuv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r <= FADE_RESET;
    end else if (cfg_we) begin
      fade_r <= cfg_fade_level;
    end
  end

  yrf_rgb_stage u_rgb (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .luma      (in_luma_in),
    .cb        (in_cb_in),
    .cr        (in_cr_in),
    .out_valid (rgb_valid),
    .out_ready (rgb_ready),
    .rgb       (rgb)
  );

  yrf_fade_stage u_fade (
    .clk        (clk),
    .rst_n      (rst_n),
    .fade_level (fade_r),
    .in_valid   (rgb_valid),
    .in_ready   (rgb_ready),
    .rgb_in     (rgb),
    .out_valid  (fade_valid),
    .out_ready  (fade_ready),
    .rgb_out    (rgb_faded)
  );

  yrf_yuv_stage u_yuv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fade_valid),
    .in_ready  (fade_ready),
    .rgb       (rgb_faded),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .yuv       (yuv)
  );

  assign out_luma_out = yuv.y;
  assign out_cb_out   = yuv.u;
  assign out_cr_out   = yuv.v;

endmodule

// File: hw/rtl/yrf_rgb_stage.sv
// yrf_rgb_stage: two pipeline stages, coefficient products then sum, floor
// shift and clamp to RGB. Depends on yrf_pkg.
`timescale 1ns / 1ps

module yrf_rgb_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [yrf_pkg::PIX_W-1:0]  luma,
  input  logic [yrf_pkg::PIX_W-1:0]  cb,
  input  logic [yrf_pkg::PIX_W-1:0]  cr,
  output logic                       out_valid,
  input  logic                       out_ready,
  output yrf_pkg::rgb_t              rgb
);
  import yrf_pkg::*;

  logic signed [8:0]  yv, uv, vv;
  logic               s1_valid_r, s2_valid_r;
  logic               s1_en, s2_en;
  logic signed [19:0] p_y_r, p_rv_r, p_gu_r, p_gv_r, p_bu_r;
  logic signed [19:0] sum_r, sum_g, sum_b;
  rgb_t               rgb_r, rgb_nxt;

  assign yv = $signed({1'b0, luma}) - 9'sd16;
  assign uv = $signed({1'b0, cb}) - 9'sd128;
  assign vv = $signed({1'b0, cr}) - 9'sd128;

  assign s2_en    = !s2_valid_r || out_ready;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_en) s1_valid_r <= in_valid;
      if (s2_en) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      p_y_r  <= 20'(yv) * 20'(C_Y);
      p_rv_r <= 20'(vv) * 20'(C_RV);
      p_gu_r <= 20'(uv) * 20'(C_GU);
      p_gv_r <= 20'(vv) * 20'(C_GV);
      p_bu_r <= 20'(uv) * 20'(C_BU);
    end
  end

  // arithmetic shift by 8 == floor
  always_comb begin
    sum_r = p_y_r + p_rv_r;
    sum_g = p_y_r - p_gu_r - p_gv_r;
    sum_b = p_y_r + p_bu_r;
    rgb_nxt.r = clamp12(sum_r[19:8]);
    rgb_nxt.g = clamp12(sum_g[19:8]);
    rgb_nxt.b = clamp12(sum_b[19:8]);
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign rgb       = rgb_r;

endmodule

// File: hw/rtl/yrf_fade_stage.sv
// yrf_fade_stage: one pipeline stage scaling each RGB channel by the fade
// level / 256. Depends on yrf_pkg.
`timescale 1ns / 1ps

module yrf_fade_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [yrf_pkg::PIX_W-1:0]  fade_level,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  yrf_pkg::rgb_t              rgb_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output yrf_pkg::rgb_t              rgb_out
);
  import yrf_pkg::*;

  logic         valid_r;
  logic         en;
  logic [15:0]  mr, mg, mb;
  rgb_t         rgb_r;

  assign en       = !valid_r || out_ready;
  assign in_ready = en;

  assign mr = 16'(rgb_in.r) * 16'(fade_level);
  assign mg = 16'(rgb_in.g) * 16'(fade_level);
  assign mb = 16'(rgb_in.b) * 16'(fade_level);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      rgb_r.r <= mr[15:8];
      rgb_r.g <= mg[15:8];
      rgb_r.b <= mb[15:8];
    end
  end

  assign out_valid = valid_r;
  assign rgb_out   = rgb_r;

endmodule

// File: hw/rtl/yrf_yuv_stage.sv
// yrf_yuv_stage: two pipeline stages, RGB -> YUV products then sum, floor
// shift, offset and saturation. Depends on yrf_pkg.
`timescale 1ns / 1ps

module yrf_yuv_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  yrf_pkg::rgb_t  rgb,
  output logic           out_valid,
  input  logic           out_ready,
  output yrf_pkg::yuv_t  yuv
);
  import yrf_pkg::*;

  logic               s1_valid_r, s2_valid_r;
  logic               s1_en, s2_en;
  logic signed [17:0] rs, gs, bs;
  logic signed [17:0] p_yr_r, p_yg_r, p_yb_r;
  logic signed [17:0] p_ur_r, p_ug_r, p_ub_r;
  logic signed [17:0] p_vr_r, p_vg_r, p_vb_r;
  logic signed [17:0] sy, su, sv;
  logic signed [11:0] oy, ou, ov;
  yuv_t               yuv_r, yuv_nxt;

  assign rs = 18'($signed({1'b0, rgb.r}));
  assign gs = 18'($signed({1'b0, rgb.g}));
  assign bs = 18'($signed({1'b0, rgb.b}));

  assign s2_en    = !s2_valid_r || out_ready;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_en) s1_valid_r <= in_valid;
      if (s2_en) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      p_yr_r <= rs * 18'(C_YR);
      p_yg_r <= gs * 18'(C_YG);
      p_yb_r <= bs * 18'(C_YB);
      p_ur_r <= rs * 18'(C_UR);
      p_ug_r <= gs * 18'(C_UG);
      p_ub_r <= bs * 18'(C_UB);
      p_vr_r <= rs * 18'(C_VR);
      p_vg_r <= gs * 18'(C_VG);
      p_vb_r <= bs * 18'(C_VB);
    end
  end

  // floor shift keeps the sign of the sum
  always_comb begin
    sy = p_yr_r + p_yg_r + p_yb_r;
    su = p_ur_r + p_ug_r + p_ub_r;
    sv = p_vr_r + p_vg_r + p_vb_r;
    oy = 12'($signed(sy[17:8])) + 12'(OFS_Y);
    ou = 12'($signed(su[17:8])) + 12'(OFS_C);
    ov = 12'($signed(sv[17:8])) + 12'(OFS_C);
    yuv_nxt.y = clamp12(oy);
    yuv_nxt.u = clamp12(ou);
    yuv_nxt.v = clamp12(ov);
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      yuv_r <= yuv_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign yuv       = yuv_r;

endmodule

// File: hw/rtl/yrf_checker.sv
// yrf_checker: port-level assertions for yuv_rgb_fade_yuv_pixel_core, bound
// to the top level. Depends on yrf_pkg.
`timescale 1ns / 1ps

module yrf_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [yrf_pkg::PIX_W-1:0]  out_luma_out,
  input  logic [yrf_pkg::PIX_W-1:0]  out_cb_out,
  input  logic [yrf_pkg::PIX_W-1:0]  out_cr_out
);
  import yrf_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_luma_out)
      && $stable(out_cb_out) && $stable(out_cr_out))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
      |=> out_valid)
    else $error("request did not reach output in 5 cycles");

endmodule

bind yuv_rgb_fade_yuv_pixel_core yrf_checker u_yrf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_luma_out (out_luma_out),
  .out_cb_out   (out_cb_out),
  .out_cr_out   (out_cr_out)
);
